[rtl/core/ecr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

    // Number of tracked slots and the fixed-point format of the coordinate.
    localparam int SLOTS         = 5;
    localparam int FRACTION_BITS = 16;

    // Field widths.
    localparam int VALUE_BITS = 40;
    localparam int SLOT_BITS  = 3;
    localparam int OUT_BITS   = 25;

    // Error sum storage: one entry per slot, axis and sign.
    localparam int ENTRIES   = SLOTS * 4;
    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SUM_BITS  = FRACTION_BITS + 1;
    localparam int WORD_BITS = 2 * SUM_BITS;
    localparam int INT_BITS  = VALUE_BITS - FRACTION_BITS;

    typedef logic [SUM_BITS-1:0]  t_sum;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_BITS-1:0]  t_idx;

    // Fixed-point one and one half in the sum width.
    localparam t_sum SUM_ONE  = t_sum'(1) << FRACTION_BITS;
    localparam t_sum SUM_HALF = t_sum'(1) << (FRACTION_BITS - 1);

endpackage

`default_nettype wire

[rtl/core/ecr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ecr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/error_compensated_coordinate_rounding.sv]
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless the output stalls; the error sum memory is read
// as a transaction is accepted and is modified and written back in the second stage, with
// forwarding between items. Each item passes the stage 1 and output registers.
// Reset (synchronous, active low) empties the pipeline and marks every error sum
// as zero through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module error_compensated_coordinate_rounding (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic signed [ecr_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic                                  i_x_axis,
    input  wire logic [ecr_pkg::SLOT_BITS-1:0]         i_slot,
    input  wire logic                                  i_clear_first,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [ecr_pkg::OUT_BITS-1:0]        o_rounded
);

    localparam int VB = ecr_pkg::VALUE_BITS;
    localparam int FB = ecr_pkg::FRACTION_BITS;
    localparam int SB = ecr_pkg::SUM_BITS;
    localparam int OB = ecr_pkg::OUT_BITS;
    localparam int IB = ecr_pkg::INT_BITS;
    localparam int NE = ecr_pkg::ENTRIES;

    // ------------------------------------------------------------------
    // Stage 0: take the transaction, form the magnitude and the entry
    // index, and start the memory read. The entry index is
    // slot * 4 + x_axis * 2 + negative.
    // ------------------------------------------------------------------
    logic                in_accept;
    logic                s0_neg;
    logic [VB-1:0]       s0_mag;
    logic                s0_track;
    logic [31:0]         s0_idx_full;
    ecr_pkg::t_idx       s0_idx;

    always_comb begin
        s0_neg      = i_value[VB-1];
        s0_mag      = s0_neg ? (VB'(0) - VB'(i_value)) : VB'(i_value);
        s0_track    = (32'(i_slot) < 32'(ecr_pkg::SLOTS));
        s0_idx_full = (32'(i_slot) * 32'd4) + (32'(i_x_axis) * 32'd2) + 32'(s0_neg);
        s0_idx      = s0_idx_full[ecr_pkg::IDX_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 1 registers. The memory read data lines up with this stage.
    // ------------------------------------------------------------------
    logic                r_s1_valid;
    logic                r_s1_neg;
    logic [VB-1:0]       r_s1_mag;
    logic                r_s1_track;
    logic                r_s1_clear;
    ecr_pkg::t_idx       r_s1_idx;
    logic                r_s1_fwd_hit;
    ecr_pkg::t_word      r_s1_fwd_data;

    // Per-entry valid bits: an entry that is not valid reads as zero.
    logic [NE-1:0]       r_valid;
    logic [NE-1:0]       n_valid;

    // Output register.
    logic                r_out_valid;
    logic [OB-1:0]       r_out_rounded;

    logic                s1_advance;
    logic                wr_en;
    ecr_pkg::t_word      wr_data;
    ecr_pkg::t_word      ram_rdata;

    // Stage 1 moves on whenever the output register is empty or being drained,
    // so a waiting result never blocks the next transaction on its own.
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Stage 1: read-modify-write of the error sums.
    // The previous item writes back at the same edge at which this item's
    // read happens, so that write is captured at accept time and forwarded.
    // While this stage stalls no other write can occur and the read data
    // holds, because the memory reads only on an accepted transaction.
    // ------------------------------------------------------------------
    ecr_pkg::t_word      cur_word;
    ecr_pkg::t_sum       cur_low;
    ecr_pkg::t_sum       cur_high;
    ecr_pkg::t_sum       frac;
    ecr_pkg::t_sum       new_sum;
    logic [IB-1:0]       int_part;
    logic [OB-1:0]       mag_res;
    logic [OB-1:0]       signed_res;
    logic                lower_half;
    logic [VB:0]         byp_add;
    logic [VB:0]         byp_sub;

    always_comb begin
        if (r_s1_clear) begin
            cur_word = '0;
        end else if (r_s1_fwd_hit) begin
            cur_word = r_s1_fwd_data;
        end else if (r_valid[r_s1_idx]) begin
            cur_word = ram_rdata;
        end else begin
            cur_word = '0;
        end
        cur_low    = cur_word[SB-1:0];
        cur_high   = cur_word[2*SB-1:SB];
        frac       = {1'b0, r_s1_mag[FB-1:0]};
        int_part   = r_s1_mag[VB-1:FB];
        lower_half = (frac < ecr_pkg::SUM_HALF);

        // Each sum stays below one and a half, so the add cannot overflow,
        // and reaching one is simply the top bit of the sum.
        if (lower_half) begin
            new_sum = cur_low + frac;
        end else begin
            new_sum = cur_high + (ecr_pkg::SUM_ONE - frac);
        end

        if (new_sum[SB-1]) begin
            mag_res = lower_half ? (OB'(int_part) + OB'(1)) : OB'(int_part);
            new_sum = new_sum - ecr_pkg::SUM_ONE;
        end else begin
            mag_res = lower_half ? OB'(int_part) : (OB'(int_part) + OB'(1));
        end

        if (lower_half) begin
            wr_data = {cur_high, new_sum};
        end else begin
            wr_data = {new_sum, cur_low};
        end

        // Untracked slots round a positive value half up; a negative value
        // gives the floor of (magnitude - half), clamped at zero, before the
        // sign is put back.
        byp_add = {1'b0, r_s1_mag} + (VB + 1)'(ecr_pkg::SUM_HALF);
        byp_sub = {1'b0, r_s1_mag} - (VB + 1)'(ecr_pkg::SUM_HALF);
        if (!r_s1_track) begin
            if (!r_s1_neg) begin
                mag_res = byp_add[VB:FB];
            end else if (byp_sub[VB]) begin
                mag_res = '0;
            end else begin
                mag_res = OB'(byp_sub[VB-1:FB]);
            end
        end

        signed_res = r_s1_neg ? (OB'(0) - mag_res) : mag_res;
    end

    assign wr_en = s1_advance && r_s1_track;

    // A clearing item wipes every sum before its own update lands.
    always_comb begin
        n_valid = r_valid;
        if (wr_en) begin
            if (r_s1_clear) begin
                n_valid = '0;
            end
            n_valid[r_s1_idx] = 1'b1;
        end
    end

    ecr_ram #(
        .WIDTH (ecr_pkg::WORD_BITS),
        .DEPTH (NE)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_idx),
        .i_wdata (wr_data),
        .i_re    (in_accept),
        .i_raddr (s0_idx),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_valid <= n_valid;
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_neg      <= s0_neg;
            r_s1_mag      <= s0_mag;
            r_s1_track    <= s0_track;
            r_s1_clear    <= i_clear_first;
            r_s1_idx      <= s0_idx;
            r_s1_fwd_hit  <= wr_en && (r_s1_idx == s0_idx);
            r_s1_fwd_data <= wr_data;
        end
        if (s1_advance) begin
            r_out_rounded <= signed_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rounded   = r_out_rounded;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every sum written back is below one.
    a_sum_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (!wr_data[SB-1] && !wr_data[2*SB-1]))
        else $error("error sum written back at or above one");

    // After a clearing transaction only its own entry holds a sum.
    a_clear_leaves_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_track && r_s1_clear) |=> $onehot(r_valid))
        else $error("clear left more than the updated entry valid");

    // Untracked slots never touch the error state.
    a_bypass_no_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && !r_s1_track) |=> $stable(r_valid))
        else $error("untracked slot changed error state");

    // A stalled stage 1 item is kept, not dropped.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |=> r_s1_valid)
        else $error("stage 1 transaction lost during stall");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // The watchdog gives up after this many cycles in which neither channel
    // moves a transaction. The longest legal quiet stretch is the receiver
    // hold-off plus one long gap, which is far below this.
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_MAX = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [ecr_pkg::VALUE_BITS-1:0] i_value;
    logic i_x_axis;
    logic [ecr_pkg::SLOT_BITS-1:0] i_slot;
    logic i_clear_first;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [ecr_pkg::OUT_BITS-1:0] o_rounded;

    error_compensated_coordinate_rounding dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_x_axis     (i_x_axis),
        .i_slot       (i_slot),
        .i_clear_first(i_clear_first),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rounded    (o_rounded)
    );

    // 20 ns period, low half first so that no rising edge falls at time zero.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the error sums, indexed by slot, axis and sign the same
    // way the block indexes its memory.
    ecr_pkg::t_sum low_err_sum [ecr_pkg::ENTRIES];
    ecr_pkg::t_sum high_err_sum [ecr_pkg::ENTRIES];

    // Rounded values still owed by the block, oldest first.
    logic signed [ecr_pkg::OUT_BITS-1:0] expected_rounded [$];

    int fail_count = 0;
    int items_in = 0;
    int results_out = 0;
    int bypass_items = 0;
    int corrections = 0;
    int stall_cycles = 0;

    // The sender asks for a long receiver hold-off by bumping the first
    // counter; the receiver serves it and bumps the second.
    int hold_off_asked = 0;
    int hold_off_done = 0;

    // While set, neither side inserts random idle cycles.
    bit no_idle = 1'b0;

    // Most gaps are zero or short, about one in ten is long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Works out the rounded value for one input transaction and advances the
    // shadow error sums exactly as the block is meant to.
    function automatic logic signed [ecr_pkg::OUT_BITS-1:0] predict_rounded(
        input logic signed [ecr_pkg::VALUE_BITS-1:0] value,
        input logic                                  x_axis,
        input logic [ecr_pkg::SLOT_BITS-1:0]         slot,
        input logic                                  clear_first
    );
        logic neg;
        logic [ecr_pkg::VALUE_BITS:0] mag;
        logic [ecr_pkg::OUT_BITS-1:0] ip;
        logic [ecr_pkg::OUT_BITS-1:0] res;
        logic [ecr_pkg::FRACTION_BITS-1:0] frac;
        ecr_pkg::t_sum s;
        int idx;

        neg = value[ecr_pkg::VALUE_BITS-1];
        // One extra bit keeps the magnitude of the most negative input exact.
        mag = neg ? -{1'b1, value} : {1'b0, value};
        ip = ecr_pkg::OUT_BITS'(mag[ecr_pkg::VALUE_BITS-1:ecr_pkg::FRACTION_BITS]);
        frac = mag[ecr_pkg::FRACTION_BITS-1:0];

        if (int'(slot) >= ecr_pkg::SLOTS) begin
            // Untracked slots round a positive value half up; a negative value
            // takes the floor of (magnitude - half) before the sign goes back.
            bypass_items++;
            if (!neg)
                res = ecr_pkg::OUT_BITS'((mag + ecr_pkg::SUM_HALF) >> ecr_pkg::FRACTION_BITS);
            else if (mag <= ecr_pkg::SUM_HALF)
                res = '0;
            else
                res = ecr_pkg::OUT_BITS'((mag - ecr_pkg::SUM_HALF) >> ecr_pkg::FRACTION_BITS);
        end else begin
            if (clear_first) begin
                for (int i = 0; i < ecr_pkg::ENTRIES; i++) begin
                    low_err_sum[i] = '0;
                    high_err_sum[i] = '0;
                end
            end
            idx = int'(slot) * 4 + int'(x_axis) * 2 + int'(neg);
            if (frac < ecr_pkg::SUM_HALF) begin
                // Rounded down: the dropped fraction piles up on the low side.
                s = low_err_sum[idx] + frac;
                if (s >= ecr_pkg::SUM_ONE) begin
                    res = ip + 1'b1;
                    s = s - ecr_pkg::SUM_ONE;
                    corrections++;
                end else begin
                    res = ip;
                end
                low_err_sum[idx] = s;
            end else begin
                // Rounded up: the added amount piles up on the high side.
                s = high_err_sum[idx] + (ecr_pkg::SUM_ONE - frac);
                if (s >= ecr_pkg::SUM_ONE) begin
                    res = ip;
                    s = s - ecr_pkg::SUM_ONE;
                    corrections++;
                end else begin
                    res = ip + 1'b1;
                end
                high_err_sum[idx] = s;
            end
        end
        return neg ? -res : res;
    endfunction

    task automatic log_failure(input string text);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, text);
    endtask

    // Offers one input transaction after a random gap and waits until the
    // block takes it. Valid stays high on return, so a back-to-back item
    // needs no second assignment to it in the same time step.
    task automatic offer_coordinate(
        input logic signed [ecr_pkg::VALUE_BITS-1:0] value,
        input logic                                  x_axis,
        input logic [ecr_pkg::SLOT_BITS-1:0]         slot,
        input logic                                  clear_first,
        input logic                                  has_lit,
        input logic signed [ecr_pkg::OUT_BITS-1:0]   lit
    );
        int gap;
        logic signed [ecr_pkg::OUT_BITS-1:0] want;

        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value <= value;
        i_x_axis <= x_axis;
        i_slot <= slot;
        i_clear_first <= clear_first;
        do
            @(posedge i_clk);
        while (!o_in_ready);

        // The predictor runs for every row so that the shadow sums follow
        // the block; a typed-in value, where given, is what gets checked.
        want = predict_rounded(value, x_axis, slot, clear_first);
        if (has_lit)
            want = lit;
        expected_rounded.push_back(want);
        items_in++;
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (expected_rounded.size() != 0)
            @(posedge i_clk);
    endtask

    // Directed rows. A typed-in result is given only where it is plain from
    // the rounding rule: values after reset, field extremes and the bypass
    // slots. The compensation runs are left to the predictor.
    typedef struct packed {
        logic signed [ecr_pkg::VALUE_BITS-1:0] value;
        logic                                  x_axis;
        logic [ecr_pkg::SLOT_BITS-1:0]         slot;
        logic                                  clear_first;
        logic                                  has_lit;
        logic signed [ecr_pkg::OUT_BITS-1:0]   lit;
    } t_coord_row;

    localparam int DIR_ROWS = 25;

    t_coord_row dir_rows [DIR_ROWS] = '{
        // Zero straight after reset, then the largest positive and the most
        // negative coordinate on tracked slots.
        '{40'sh00_0000_0000, 1'b0, 3'd0, 1'b0, 1'b1, 25'sd0},
        '{40'sh7F_FFFF_FFFF, 1'b0, 3'd0, 1'b0, 1'b1, 25'sd8388608},
        '{40'sh80_0000_0000, 1'b1, 3'd1, 1'b0, 1'b1, -25'sd8388608},
        // Bypass slots: extremes, exact halves, the smallest negative value
        // and a clear request that must not touch the sums.
        '{40'sh80_0000_0000, 1'b0, 3'd7, 1'b0, 1'b1, -25'sd8388607},
        '{40'sh7F_FFFF_FFFF, 1'b1, 3'd5, 1'b0, 1'b1, 25'sd8388608},
        '{40'shFF_FFFF_8000, 1'b0, 3'd6, 1'b0, 1'b1, 25'sd0},
        '{40'sh00_0000_8000, 1'b1, 3'd5, 1'b0, 1'b1, 25'sd1},
        '{40'shFF_FFFF_FFFF, 1'b0, 3'd6, 1'b0, 1'b1, 25'sd0},
        '{40'sh00_0002_4000, 1'b1, 3'd7, 1'b1, 1'b1, 25'sd2},
        // A quarter four times: the low-side sum reaches one on the fourth.
        '{40'sh00_0000_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0000_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0000_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0000_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        // Minus three quarters four times: the high-side sum of the
        // negative entry reaches one on the fourth.
        '{40'shFF_FFFF_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        '{40'shFF_FFFF_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        '{40'shFF_FFFF_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        '{40'shFF_FFFF_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0},
        // Exact halves on the last tracked slot.
        '{40'sh00_0003_8000, 1'b1, 3'd4, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0003_8000, 1'b1, 3'd4, 1'b0, 1'b0, 25'sd0},
        // Just below one half, three times: the sum climbs close to its
        // largest possible value before it wraps.
        '{40'sh00_0000_7FFF, 1'b1, 3'd3, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0000_7FFF, 1'b1, 3'd3, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0000_7FFF, 1'b1, 3'd3, 1'b0, 1'b0, 25'sd0},
        // Clear on a tracked slot, then touch another entry and the cleared entry again.
        '{40'sh00_0000_4000, 1'b0, 3'd2, 1'b1, 1'b0, 25'sd0},
        '{40'sh7F_FFFF_FFFF, 1'b0, 3'd0, 1'b0, 1'b0, 25'sd0},
        '{40'sh00_0000_4000, 1'b0, 3'd2, 1'b0, 1'b0, 25'sd0}
    };

    // Random stimulus keeps a current slot, axis and sign so that about four
    // in ten transactions continue a run on one error entry and drive its sums
    // through several corrections.
    logic [ecr_pkg::SLOT_BITS-1:0] run_slot = '0;
    logic run_axis = 1'b0;
    logic run_neg = 1'b0;

    task automatic offer_random_coordinate();
        int r;
        logic [ecr_pkg::FRACTION_BITS-1:0] frac;
        logic [ecr_pkg::VALUE_BITS-1:0] mag;
        logic signed [ecr_pkg::VALUE_BITS-1:0] value;
        logic [ecr_pkg::SLOT_BITS-1:0] slot;
        logic axis;
        logic neg;

        r = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
            0: frac = '0;
            1: frac = ecr_pkg::FRACTION_BITS'(ecr_pkg::SUM_HALF - 1'b1);
            2: frac = ecr_pkg::FRACTION_BITS'(ecr_pkg::SUM_HALF);
            3: frac = '1;
            default: frac = ecr_pkg::FRACTION_BITS'($urandom);
        endcase

        if (r < 40) begin
            slot = run_slot;
            axis = run_axis;
            neg = run_neg;
        end else begin
            slot = ($urandom_range(0, 9) < 8)
                 ? ecr_pkg::SLOT_BITS'($urandom_range(0, ecr_pkg::SLOTS - 1))
                 : ecr_pkg::SLOT_BITS'($urandom_range(ecr_pkg::SLOTS, 7));
            axis = 1'($urandom_range(0, 1));
            neg = 1'($urandom_range(0, 1));
        end

        if (r < 70) begin
            // Small coordinates as a pen stroke would produce.
            mag = {ecr_pkg::INT_BITS'($urandom_range(0, 40)), frac};
            value = neg ? -mag : mag;
        end else if (r < 90) begin
            value = ecr_pkg::VALUE_BITS'({$urandom, $urandom});
        end else begin
            case ($urandom_range(0, 3))
                0: value = {1'b0, {(ecr_pkg::VALUE_BITS - 1){1'b1}}}
                         - ecr_pkg::VALUE_BITS'($urandom_range(0, 3));
                1: value = {1'b1, {(ecr_pkg::VALUE_BITS - 1){1'b0}}}
                         + ecr_pkg::VALUE_BITS'($urandom_range(0, 3));
                2: value = {1'b0, {(ecr_pkg::INT_BITS - 1){1'b1}}, frac};
                default: value = {1'b1, {(ecr_pkg::INT_BITS - 1){1'b0}}, frac};
            endcase
        end

        if (int'(slot) < ecr_pkg::SLOTS) begin
            run_slot = slot;
            run_axis = axis;
            run_neg = value[ecr_pkg::VALUE_BITS-1];
        end
        offer_coordinate(value, axis, slot, $urandom_range(0, 49) == 0, 1'b0, '0);
    endtask

    // Result side: a random ready pattern, plus one long hold-off whenever
    // the sender asks for it, counted here in cycles.
    initial begin
        int run;
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            run = $urandom_range(1, 16);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (hold_off_asked != hold_off_done) begin
                hold_off_done++;
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = idle_gap();
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Result checking and the watchdog. Both handshakes are sampled at the
    // rising edge, before anything driven at that edge takes effect.
    always @(posedge i_clk) begin : result_check
        logic signed [ecr_pkg::OUT_BITS-1:0] want;
        logic took_in;
        logic took_out;
        if (i_rst_n) begin
            took_in = i_in_valid && o_in_ready;
            took_out = o_out_valid && i_out_ready;
            if (took_out) begin
                results_out++;
                if (expected_rounded.size() == 0) begin
                    log_failure($sformatf("result %0d arrived with none outstanding",
                                          o_rounded));
                end else begin
                    want = expected_rounded.pop_front();
                    if (o_rounded !== want)
                        log_failure($sformatf("result %0d: rounded expected %0d, got %0d",
                                              results_out, want, o_rounded));
                end
            end
            if (took_in || took_out) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("[%0t] watchdog: no transaction for %0d cycles, %0d outstanding",
                             $realtime, STALL_LIMIT, expected_rounded.size());
                    $display("** error_compensated_coordinate_rounding: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_value = '0;
        i_x_axis = 1'b0;
        i_slot = '0;
        i_clear_first = 1'b0;
        for (int i = 0; i < ecr_pkg::ENTRIES; i++) begin
            low_err_sum[i] = '0;
            high_err_sum[i] = '0;
        end

        // Synchronous reset held from the start, released once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_coordinate(dir_rows[i].value, dir_rows[i].x_axis, dir_rows[i].slot,
                             dir_rows[i].clear_first, dir_rows[i].has_lit, dir_rows[i].lit);

        repeat (150) offer_random_coordinate();

        // Back the pipeline up: the receiver holds off for a long stretch
        // while the sender keeps offering without gaps.
        hold_off_asked++;
        no_idle = 1'b1;
        repeat (60) offer_random_coordinate();
        no_idle = 1'b0;

        // The sender waits here until every result has come back.
        pause_until_drained();

        // A stretch at full rate on both sides.
        no_idle = 1'b1;
        repeat (80) offer_random_coordinate();
        no_idle = 1'b0;

        repeat (110) offer_random_coordinate();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d coordinates (%0d on bypass slots) and %0d results checked.",
                 items_in, bypass_items, results_out);
        $display("Saw %0d error corrections, %0d receiver hold-off(s), %0d mismatches.",
                 corrections, hold_off_done, fail_count);
        if (fail_count == 0)
            $display("** error_compensated_coordinate_rounding: PASSED **");
        else
            $display("** error_compensated_coordinate_rounding: FAILED **");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ecr_pkg.sv
rtl/core/ecr_ram.sv
rtl/core/error_compensated_coordinate_rounding.sv
bench/tb_top.sv
